// ----- design/ssnf_pkg.sv -----
package ssnf_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int MAG_W = 27;
	localparam int CNT_W = 4;
	localparam int DP_W = 3;
	localparam int SEG_W = 8;
	localparam int POW_W = 34;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CNT_W-1:0] DIGIT_COUNT_RST = 4'd8;
	localparam logic REG_DIGIT_COUNT = 1'b0;

	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;
	localparam logic [SEG_W-1:0] SEG_POINT = 8'h01;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

	typedef struct packed {
		logic load;
		logic shift_out;
	} ssnf_bcd_ctrl_t;

	typedef struct packed {
		logic       done;
		logic [3:0] digit;
	} ssnf_bcd_stat_t;

	function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'hfc;
			4'd1: s = 8'h60;
			4'd2: s = 8'hda;
			4'd3: s = 8'hf2;
			4'd4: s = 8'h66;
			4'd5: s = 8'hb6;
			4'd6: s = 8'hbe;
			4'd7: s = 8'he0;
			4'd8: s = 8'hfe;
			4'd9: s = 8'hf6;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] idx);
		logic [POW_W-1:0] p;
		unique case (idx)
			4'd0: p = 34'd1;
			4'd1: p = 34'd10;
			4'd2: p = 34'd100;
			4'd3: p = 34'd1000;
			4'd4: p = 34'd10000;
			4'd5: p = 34'd100000;
			4'd6: p = 34'd1000000;
			4'd7: p = 34'd10000000;
			4'd8: p = 34'd100000000;
			4'd9: p = 34'd1000000000;
			4'd10: p = 34'd10000000000;
			default: p = {POW_W{1'b1}};
		endcase
		return p;
	endfunction

endpackage

// ----- design/ssnf_if.sv -----
interface ssnf_item_if import ssnf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] magnitude;
	logic             negative;
	logic [DP_W-1:0]  point_position;
	logic             blank_leading;

	modport source (output valid, magnitude, negative, point_position, blank_leading,
		input ready);
	modport sink (input valid, magnitude, negative, point_position, blank_leading,
		output ready);
endinterface

interface ssnf_result_if import ssnf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segments;
	logic             last;
	logic             overflow;

	modport source (output valid, segments, last, overflow, input ready);
	modport sink (input valid, segments, last, overflow, output ready);
endinterface

// ----- design/ssnf_apb_regs.sv -----
module ssnf_apb_regs import ssnf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [CNT_W-1:0]  digit_count
);

	logic [CNT_W-1:0] digit_count_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[2] == REG_DIGIT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= DIGIT_COUNT_RST;
		end else if (wr_en) begin
			digit_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DIGIT_COUNT) ?
		{{(DATA_W-CNT_W){1'b0}}, digit_count_q} : '0;
	assign digit_count = digit_count_q;

endmodule

// ----- design/ssnf_bcd_unit.sv -----
module ssnf_bcd_unit import ssnf_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ssnf_bcd_ctrl_t   ctrl,
	input  logic [MAG_W-1:0] bin,
	output ssnf_bcd_stat_t   stat
);

	localparam int BCD_W = 4 * MAX_DIGITS;
	localparam int CW = $clog2(MAG_W + 1);

	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] bcd_adj;
	logic [MAG_W-1:0] bin_q;
	logic [CW-1:0]    cnt_q;
	logic             run;

	// Shift-and-add-three conversion, one binary bit per cycle.
	genvar j;
	generate
		for (j = 0; j < MAX_DIGITS; j++) begin : g_adj
			assign bcd_adj[4*j +: 4] = (bcd_q[4*j +: 4] >= 4'd5) ?
				bcd_q[4*j +: 4] + 4'd3 : bcd_q[4*j +: 4];
		end
	endgenerate

	assign run = (cnt_q != CW'(MAG_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(MAG_W);
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (run) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bcd_q <= '0;
			bin_q <= bin;
		end else if (run) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[MAG_W-1]};
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
		end else if (ctrl.shift_out) begin
			bcd_q <= bcd_q >> 4;
		end
	end

	assign stat.done = !run;
	assign stat.digit = bcd_q[3:0];

endmodule

// ----- design/seven_segment_number_formatter.sv -----
// Formats a signed, pre-scaled decimal number for a seven-segment display.
// The item channel carries the magnitude (already multiplied by ten to the
// number of decimal places), the sign, the point position and a request to
// blank leading zeros. The result channel returns one segment byte per active
// position, from the last position to the first, with last set on the byte
// for the first position. A number that does not fit gives one transaction
// with overflow set and segments zero instead.
// The number of active positions is set through the APB register at offset 0.
// A transaction is captured, converted by the bit-serial binary-to-BCD unit and,
// once the unit has finished, checked for fit on the shared comparator; then its
// bytes are emitted one by one, or the single overflow byte instead.
// The item channel is ready only between transactions; it reopens as soon as
// the final byte sits in the output register. A stalled receiver holds the
// output register and pauses emission without losing bytes. Reset sets eight
// positions and leaves the block idle with no result pending.
module seven_segment_number_formatter import ssnf_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	ssnf_item_if.sink         item,
	ssnf_result_if.source     result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] digit_count;
	logic [CNT_W-1:0] n_clamp;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [DP_W-1:0]  dp_q;
	logic             blank_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] k_q;

	logic             res_valid_q;
	logic [SEG_W-1:0] res_seg_q;
	logic             res_last_q;
	logic             res_ovf_q;

	ssnf_bcd_ctrl_t   bcd_ctrl;
	ssnf_bcd_stat_t   bcd_stat;

	logic             accept;
	logic             slot_free;
	logic             emit_fire;
	logic             err_fire;
	logic [CNT_W-1:0] cmp_idx;
	logic             lt;
	logic             no_int_pos;
	logic             pos0;
	logic [SEG_W-1:0] seg_next;

	ssnf_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.digit_count (digit_count)
	);

	ssnf_bcd_unit #(.MAX_DIGITS(MAX_DIGITS)) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bcd_ctrl),
		.bin    (item.magnitude),
		.stat   (bcd_stat)
	);

	assign n_clamp = (digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count;

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && (state_q == ST_IDLE);
	assign slot_free = !res_valid_q || result.ready;
	assign emit_fire = (state_q == ST_EMIT) && slot_free;
	assign err_fire = (state_q == ST_ERR) && slot_free;

	assign bcd_ctrl.load = accept;
	assign bcd_ctrl.shift_out = emit_fire;

	// The comparator is shared: the fit check uses ten to the number of
	// positions left for digits, emission uses ten to the digit index.
	assign cmp_idx = (state_q == ST_CHECK) ? (n_q - {{(CNT_W-1){1'b0}}, neg_q}) : k_q;
	assign lt = {{(POW_W-MAG_W){1'b0}}, mag_q} < pow10(cmp_idx);
	assign no_int_pos = {1'b0, n_q} <
		({{(CNT_W+1-DP_W){1'b0}}, dp_q} + {{CNT_W{1'b0}}, neg_q} + (CNT_W+1)'(1));

	assign pos0 = (k_q == n_q - CNT_W'(1));

	always_comb begin
		if (neg_q && pos0) begin
			seg_next = SEG_MINUS;
		end else if (blank_q && (k_q > {{(CNT_W-DP_W){1'b0}}, dp_q}) && lt) begin
			seg_next = SEG_BLANK;
		end else begin
			seg_next = seg_encode(bcd_stat.digit);
		end
		if ((dp_q != '0) && (k_q == {{(CNT_W-DP_W){1'b0}}, dp_q})) begin
			seg_next = seg_next | SEG_POINT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bcd_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					k_q <= '0;
					state_q <= (no_int_pos || !lt) ? ST_ERR : ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						k_q <= k_q + CNT_W'(1);
						if (pos0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (err_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= item.magnitude;
			neg_q <= item.negative;
			dp_q <= item.point_position;
			blank_q <= item.blank_leading;
			n_q <= n_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= emit_fire || err_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_seg_q <= seg_next;
			res_last_q <= pos0;
			res_ovf_q <= 1'b0;
		end else if (err_fire) begin
			res_seg_q <= SEG_BLANK;
			res_last_q <= 1'b0;
			res_ovf_q <= 1'b1;
		end
	end

	assign result.valid = res_valid_q;
	assign result.segments = res_seg_q;
	assign result.last = res_last_q;
	assign result.overflow = res_ovf_q;

`ifndef NO_ASSERTIONS
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV))
		else $error("accepted transaction did not start conversion");

	a_check_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> bcd_stat.done)
		else $error("fit check before conversion finished");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q < n_q))
		else $error("emission index beyond active positions");

	a_overflow_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_ovf_q) |-> ((res_seg_q == SEG_BLANK) && !res_last_q))
		else $error("overflow result carries segments or last");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import ssnf_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int NUM_ROWS = 25;
	localparam int NUM_PHASES = 10;

	localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6
	};

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic             last;
		logic             overflow;
	} seg_byte_t;

	typedef struct packed {
		logic [CNT_W-1:0] positions;
		logic [MAG_W-1:0] magnitude;
		logic             negative;
		logic [DP_W-1:0]  point;
		logic             blank;
		logic             typed;
		logic             overflow;
		logic [63:0]      glyphs;
	} number_row_t;

	// Typed glyphs hold the first position in the top byte, so the transaction
	// order runs from the bottom byte up.
	localparam number_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{4'd8, 27'd0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, 64'hfcfcfcfcfcfcfcfc},
		'{4'd8, 27'd0, 1'b0, 3'd0, 1'b1, 1'b1, 1'b0, 64'h00000000000000fc},
		'{4'd8, 27'd99999999, 1'b0, 3'd0, 1'b0, 1'b1, 1'b0, 64'hf6f6f6f6f6f6f6f6},
		'{4'd8, 27'd99999999, 1'b1, 3'd0, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd8, 27'd134217727, 1'b0, 3'd0, 1'b1, 1'b1, 1'b1, 64'h0},
		'{4'd8, 27'd100000000, 1'b0, 3'd7, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd8, 27'd0, 1'b1, 3'd7, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd8, 27'd0, 1'b0, 3'd7, 1'b1, 1'b1, 1'b0, 64'hfdfcfcfcfcfcfcfc},
		'{4'd8, 27'd0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b0, 64'h02000000000000fc},
		'{4'd8, 27'd12345678, 1'b0, 3'd2, 1'b0, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd9876543, 1'b1, 3'd3, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd1000, 1'b0, 3'd0, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd10203, 1'b0, 3'd1, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd5, 1'b0, 3'd3, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd5, 1'b1, 3'd3, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd9999999, 1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd99999999, 1'b1, 3'd1, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd8, 27'd99999999, 1'b0, 3'd7, 1'b0, 1'b0, 1'b0, 64'h0},
		'{4'd8, 27'd134217727, 1'b0, 3'd7, 1'b1, 1'b1, 1'b1, 64'h0},
		'{4'd0, 27'd0, 1'b0, 3'd0, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd1, 27'd9, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{4'd1, 27'd0, 1'b0, 3'd1, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd2, 27'd5, 1'b1, 3'd0, 1'b1, 1'b0, 1'b0, 64'h0},
		'{4'd2, 27'd7, 1'b0, 3'd3, 1'b0, 1'b1, 1'b1, 64'h0},
		'{4'd15, 27'd87654321, 1'b0, 3'd4, 1'b0, 1'b0, 1'b0, 64'h0}
	};

	localparam logic [CNT_W-1:0] PHASE_POSITIONS [NUM_PHASES] = '{
		4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd9, 4'd5, 4'd8
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ssnf_item_if   item_ch ();
	ssnf_result_if result_ch ();

	seven_segment_number_formatter i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	seg_byte_t        expected_bytes [$];
	seg_byte_t        want;
	logic [CNT_W-1:0] positions_cfg = DIGIT_COUNT_RST;
	int               error_count = 0;
	int               items_sent = 0;
	int               quiet_cycles = 0;
	bit               send_idle = 1'b1;
	bit               take_idle = 1'b1;
	bit               held_off = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic longint unsigned ten_to(input int unsigned p);
		longint unsigned r = 1;
		for (int unsigned i = 0; i < p; i++)
			r = r * 10;
		return r;
	endfunction

	function automatic void format_display(input logic [MAG_W-1:0] mag, input logic neg,
			input logic [DP_W-1:0] dp, input logic blank, input logic [CNT_W-1:0] count);
		int               n;
		int               int_pos;
		int               units;
		int               width;
		longint unsigned  whole;
		logic [3:0]       digs [MAX_DIGITS_DEF];
		logic [SEG_W-1:0] segs [MAX_DIGITS_DEF];
		n = (count > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(count);
		int_pos = n - int'(neg) - int'(dp);
		whole = mag / ten_to(dp);
		width = 1;
		while (whole >= 10) begin
			whole = whole / 10;
			width++;
		end
		if (int_pos < 1 || width > int_pos) begin
			expected_bytes.push_back('{SEG_BLANK, 1'b0, 1'b1});
			return;
		end
		units = n - 1 - int'(dp);
		for (int i = 0; i < n; i++) begin
			digs[i] = 4'((mag / ten_to(n - 1 - i)) % 10);
			segs[i] = DIGIT_GLYPH[digs[i]];
		end
		if (neg)
			segs[0] = SEG_MINUS;
		if (blank) begin
			for (int i = int'(neg); i < units; i++) begin
				if (digs[i] != 0)
					break;
				segs[i] = SEG_BLANK;
			end
		end
		if (dp != 0)
			segs[units] = segs[units] | SEG_POINT;
		for (int i = n - 1; i >= 0; i--)
			expected_bytes.push_back('{segs[i], i == 0, 1'b0});
	endfunction

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_positions(input logic [CNT_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(4 * REG_DIGIT_COUNT);
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		positions_cfg = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(value))
			note_error($sformatf("digit_count readback: expected %h, got %h",
				DATA_W'(value), prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic offer(input logic [MAG_W-1:0] mag, input logic neg,
			input logic [DP_W-1:0] dp, input logic blank);
		item_ch.valid <= 1'b1;
		item_ch.magnitude <= mag;
		item_ch.negative <= neg;
		item_ch.point_position <= dp;
		item_ch.blank_leading <= blank;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	task automatic sender_gap();
		int unsigned gap;
		if ($urandom_range(0, 24) == 0)
			send_idle = !send_idle;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		number_row_t      row;
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic [DP_W-1:0]  dp;
		logic             blank;
		int unsigned      n_eff;
		int unsigned      sel;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.magnitude <= '0;
		item_ch.negative <= 1'b0;
		item_ch.point_position <= '0;
		item_ch.blank_leading <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED_ROWS[r];
			if (row.positions != positions_cfg)
				set_positions(row.positions);
			offer(row.magnitude, row.negative, row.point, row.blank);
			if (row.typed) begin
				if (row.overflow) begin
					expected_bytes.push_back('{SEG_BLANK, 1'b0, 1'b1});
				end else begin
					for (int k = 0; k < 8; k++)
						expected_bytes.push_back('{row.glyphs[8*k +: 8], k == 7, 1'b0});
				end
			end else begin
				format_display(row.magnitude, row.negative, row.point, row.blank,
					positions_cfg);
			end
			sender_gap();
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_positions(PHASE_POSITIONS[p]);
			n_eff = (PHASE_POSITIONS[p] > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF :
				PHASE_POSITIONS[p];
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (p == 5 && k == 20)
					wait_drained();
				neg = 1'($urandom_range(0, 1));
				blank = 1'($urandom_range(0, 1));
				sel = $urandom_range(0, 9);
				if (sel < 7 && n_eff > 0) begin
					dp = DP_W'($urandom_range(0, n_eff - 1));
					if (int'(neg) + int'(dp) >= int'(n_eff))
						neg = 1'b0;
					mag = MAG_W'($urandom % ten_to($urandom_range(1, n_eff - neg)));
				end else if (sel < 9) begin
					dp = DP_W'($urandom_range(0, 7));
					mag = MAG_W'($urandom % ten_to($urandom_range(1, 9)));
				end else begin
					dp = DP_W'($urandom_range(0, 7));
					mag = MAG_W'($urandom);
				end
				offer(mag, neg, dp, blank);
				format_display(mag, neg, dp, blank, positions_cfg);
				sender_gap();
			end
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (expected_bytes.size() != 0)
			note_error($sformatf("%0d results never arrived", expected_bytes.size()));
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= 60) begin
				stall = HOLD_OFF_CYCLES;
				held_off = 1'b1;
			end else begin
				if ($urandom_range(0, 24) == 0)
					take_idle = !take_idle;
				stall = take_idle ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				note_error($sformatf("result with none expected: segments=%h last=%b overflow=%b",
					result_ch.segments, result_ch.last, result_ch.overflow));
			end else begin
				want = expected_bytes.pop_front();
				if (result_ch.segments !== want.segments || result_ch.last !== want.last ||
						result_ch.overflow !== want.overflow)
					note_error($sformatf({"expected segments=%h last=%b overflow=%b, ",
						"got segments=%h last=%b overflow=%b"},
						want.segments, want.last, want.overflow,
						result_ch.segments, result_ch.last, result_ch.overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
